### rtl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared constants, codes and controller/datapath interface types for the
// queue with delete by value.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned DataW    = 32;
  localparam int unsigned OccW     = 5;
  localparam int unsigned OutDataW = ((DataW + OccW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEL  = 2'd1,
    OP_LIST = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DEL,
    S_MISS,
    S_LIST
  } state_e;

  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    enq;
    logic    del;
    logic    emit;
    status_e status;
    logic    entry;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic hit;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/fqd_ctrl.sv
// ----------------------------------------------------------------------------
// fqd_ctrl
// Controller state machine: sequences one operation at a time and drives the
// datapath through commands.
// ----------------------------------------------------------------------------
module fqd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fqd_pkg::sts_t sts_i,
  output fqd_pkg::cmd_t cmd_o
);

  fqd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fqd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fqd_pkg::S_EXEC;
        end
      end
      fqd_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          unique case (sts_i.op)
            fqd_pkg::OP_ENQ: begin
              cmd_o.emit   = 1'b1;
              cmd_o.enq    = !sts_i.full;
              cmd_o.status = sts_i.full ? fqd_pkg::ST_FULL : fqd_pkg::ST_OK;
              state_d      = fqd_pkg::S_IDLE;
            end
            fqd_pkg::OP_DEL: begin
              if (sts_i.empty) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = fqd_pkg::ST_EMPTY;
                state_d      = fqd_pkg::S_IDLE;
              end else begin
                state_d = fqd_pkg::S_SEARCH;
              end
            end
            fqd_pkg::OP_LIST: begin
              if (sts_i.empty) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = fqd_pkg::ST_EMPTY;
                state_d      = fqd_pkg::S_IDLE;
              end else begin
                state_d = fqd_pkg::S_LIST;
              end
            end
            fqd_pkg::OP_NOP: begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = fqd_pkg::ST_OK;
              state_d      = fqd_pkg::S_IDLE;
            end
            default: state_d = fqd_pkg::S_IDLE;
          endcase
        end
      end
      fqd_pkg::S_SEARCH: begin
        if (sts_i.hit) begin
          state_d = fqd_pkg::S_DEL;
        end else if (sts_i.idx_last) begin
          state_d = fqd_pkg::S_MISS;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      fqd_pkg::S_DEL: begin
        if (sts_i.out_free) begin
          cmd_o.del    = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.status = fqd_pkg::ST_OK;
          state_d      = fqd_pkg::S_IDLE;
        end
      end
      fqd_pkg::S_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = fqd_pkg::ST_NOT_FOUND;
          state_d      = fqd_pkg::S_IDLE;
        end
      end
      fqd_pkg::S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.entry  = 1'b1;
          cmd_o.status = fqd_pkg::ST_OK;
          if (sts_i.idx_last) begin
            state_d = fqd_pkg::S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: state_d = fqd_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/fqd_dp.sv
// ----------------------------------------------------------------------------
// fqd_dp
// Datapath: entry registers, occupancy count, walk index, latched request and
// the output register.
// ----------------------------------------------------------------------------
module fqd_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   in_op_i,
  input  logic [fqd_pkg::DataW-1:0]    in_value_i,
  input  fqd_pkg::cmd_t                cmd_i,
  output fqd_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   out_status_o,
  output logic [fqd_pkg::DataW-1:0]    out_entry_o,
  output logic                         out_last_o,
  output logic [fqd_pkg::OccW-1:0]     out_occ_o
);

  logic [fqd_pkg::DataW-1:0]  store_q [fqd_pkg::Capacity];
  logic [fqd_pkg::DataW-1:0]  store_d [fqd_pkg::Capacity];
  logic [fqd_pkg::CountW-1:0] count_q, count_d;
  logic [fqd_pkg::IdxW-1:0]   idx_q, idx_d;
  fqd_pkg::op_e               op_q;
  logic [fqd_pkg::DataW-1:0]  value_q;
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 out_status_q;
  logic [fqd_pkg::DataW-1:0]  out_entry_q;
  logic                       out_last_q;
  logic [fqd_pkg::OccW-1:0]   out_occ_q;
  logic [fqd_pkg::DataW-1:0]  rd_data;
  logic                       idx_last;
  logic                       out_free;

  assign rd_data  = store_q[idx_q];
  assign idx_last = (fqd_pkg::CountW'(idx_q) + fqd_pkg::CountW'(1)) == count_q;
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.op       = op_q;
  assign sts_o.full     = count_q == fqd_pkg::CountW'(fqd_pkg::Capacity);
  assign sts_o.empty    = count_q == '0;
  assign sts_o.hit      = rd_data == value_q;
  assign sts_o.idx_last = idx_last;
  assign sts_o.out_free = out_free;

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    if (cmd_i.enq) begin
      store_d[count_q[fqd_pkg::IdxW-1:0]] = value_q;
      count_d = count_q + fqd_pkg::CountW'(1);
    end
    if (cmd_i.del) begin
      for (int i = 0; i < fqd_pkg::Capacity - 1; i++) begin
        if (fqd_pkg::IdxW'(i) >= idx_q) begin
          store_d[i] = store_q[i+1];
        end
      end
      count_d = count_q - fqd_pkg::CountW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + fqd_pkg::IdxW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (cmd_i.load) begin
      op_q    <= fqd_pkg::op_e'(in_op_i);
      value_q <= in_value_i;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_entry_q  <= cmd_i.entry ? rd_data : '0;
      out_last_q   <= cmd_i.entry ? idx_last : 1'b1;
      out_occ_q    <= fqd_pkg::OccW'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_entry_o  = out_entry_q;
  assign out_last_o   = out_last_q;
  assign out_occ_o    = out_occ_q;

endmodule

### rtl/fifo_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value
// Bounded ordered queue of signed 32-bit values with enqueue, delete of the
// first matching value and listing of all entries.
//
//   Channel  Direction  tdata                                tuser   tlast
//   s_axis   in         [31:0] value                         opcode  -
//   m_axis   out        [31:0] entry_value, [36:32] occupancy status  last
//
// One transaction is handled at a time. The delete search walks the entry
// registers one per cycle. Reset empties the queue. A stalled output holds the
// controller in place.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_value (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [fqd_pkg::DataW-1:0]     s_axis_tdata_i,  // [31:0] value
  input  logic [1:0]                    s_axis_tuser_i,  // [1:0] opcode
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [fqd_pkg::OutDataW-1:0]  m_axis_tdata_o,  // [31:0] entry_value, [36:32] occupancy
  output logic [1:0]                    m_axis_tuser_o,  // [1:0] status
  output logic                          m_axis_tlast_o
);

  fqd_pkg::cmd_t                cmd;
  fqd_pkg::sts_t                sts;
  logic [fqd_pkg::DataW-1:0]    out_entry;
  logic [fqd_pkg::OccW-1:0]     out_occ;

  fqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fqd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_entry_o  (out_entry),
    .out_last_o   (m_axis_tlast_o),
    .out_occ_o    (out_occ)
  );

  assign m_axis_tdata_o = {{(fqd_pkg::OutDataW - fqd_pkg::DataW - fqd_pkg::OccW){1'b0}},
                           out_occ, out_entry};

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the queue with delete by value. A short
// directed sequence hits the empty, full, duplicate and missing-value cases.
// Random enqueue, delete, list and no-op traffic follows, with random idle
// bursts on both streams and one long output stall. Every result is checked
// against an in-bench prediction of the queue contents.
// ----------------------------------------------------------------------------
module tb;
  import fqd_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
  } queue_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] entry_value;
    logic        last;
    logic [4:0]  occupancy;
  } queue_resp_t;

  localparam int unsigned RandomCmds  = 184;
  localparam int unsigned QuietTail   = 35;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAfter   = 70;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  queue_cmd_t  pending_cmds[$];
  queue_resp_t expected_resps[$];
  logic [31:0] held_entries[$];
  logic [31:0] hot_values[8];

  int unsigned total_cmds = 0;
  int unsigned cmds_taken = 0;
  int unsigned resps_seen = 0;
  int unsigned mismatches = 0;
  int unsigned full_hits = 0;
  int unsigned miss_hits = 0;
  int unsigned listed = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_done = 1'b0;
  bit          cmd_taken = 1'b0;
  bit          quiet = 1'b0;

  fifo_with_delete_by_value uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic push_cmd(input op_e op, input logic [31:0] value);
    queue_cmd_t c;
    c.op = op;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  task automatic apply_queue_op(input op_e op, input logic [31:0] value);
    queue_resp_t r;
    int          hit;
    bit          multi;
    hit = -1;
    multi = 1'b0;
    r.status = ST_OK;
    r.entry_value = '0;
    r.last = 1'b1;
    r.occupancy = '0;
    case (op)
      OP_ENQ: begin
        if (held_entries.size() >= Capacity) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          held_entries.push_back(value);
        end
      end
      OP_DEL: begin
        if (held_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < held_entries.size() && hit < 0; i++) begin
            if (held_entries[i] == value) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
            miss_hits++;
          end else begin
            held_entries.delete(hit);
          end
        end
      end
      OP_LIST: begin
        if (held_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          multi = 1'b1;
          for (int i = 0; i < held_entries.size(); i++) begin
            r.entry_value = held_entries[i];
            r.last = (i == held_entries.size() - 1);
            r.occupancy = 5'(held_entries.size());
            expected_resps.push_back(r);
            listed++;
          end
        end
      end
      default: begin
      end
    endcase
    if (!multi) begin
      r.occupancy = 5'(held_entries.size());
      expected_resps.push_back(r);
    end
  endtask

  // Sender: one new transaction or an idle burst after each accepted one.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || cmd_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 12);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_cmds[0].value;
          s_axis_tuser <= pending_cmds[0].op;
          void'(pending_cmds.pop_front());
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off that backs up the input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && cmds_taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    queue_resp_t want;
    queue_resp_t got;
    cmd_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_taken = 1'b1;
        cmds_taken++;
        apply_queue_op(op_e'(s_axis_tuser), s_axis_tdata);
        quiet = (cmds_taken + QuietTail >= total_cmds);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        resps_seen++;
        got.status = status_e'(m_axis_tuser);
        got.entry_value = m_axis_tdata[31:0];
        got.last = m_axis_tlast;
        got.occupancy = m_axis_tdata[36:32];
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_resps.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
          end
          if (got.entry_value != want.entry_value) begin
            $display("%0t: entry_value expected %h actual %h", $time, want.entry_value,
                     got.entry_value);
            mismatches++;
          end
          if (got.last != want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            mismatches++;
          end
          if (got.occupancy != want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                     got.occupancy);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("%0t: no transaction for %0d cycles", $time, StallLimit);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned roll;
    bit          filling;
    logic [31:0] v;
    hot_values[0] = 32'h8000_0000;
    hot_values[1] = 32'h7FFF_FFFF;
    hot_values[2] = 32'h0000_0000;
    hot_values[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) hot_values[i] = $urandom;

    // Empty queue, then fill with extremes and a duplicate, overflow, then
    // delete absent, first of duplicates and front.
    push_cmd(OP_LIST, 32'h0);
    push_cmd(OP_DEL, 32'h1234_5678);
    push_cmd(OP_NOP, 32'hFFFF_FFFF);
    push_cmd(OP_ENQ, 32'h8000_0000);
    push_cmd(OP_ENQ, 32'h7FFF_FFFF);
    push_cmd(OP_ENQ, 32'h0000_0000);
    push_cmd(OP_ENQ, 32'hFFFF_FFFF);
    push_cmd(OP_ENQ, 32'h7FFF_FFFF);
    for (int i = 5; i < Capacity; i++) push_cmd(OP_ENQ, $urandom);
    push_cmd(OP_ENQ, 32'h5555_5555);
    push_cmd(OP_LIST, 32'h0);
    push_cmd(OP_DEL, 32'h1234_5678);
    push_cmd(OP_DEL, 32'h7FFF_FFFF);
    push_cmd(OP_DEL, 32'h8000_0000);
    push_cmd(OP_LIST, 32'h0);
    push_cmd(OP_NOP, 32'h0);

    // Alternate enqueue-heavy and delete-heavy stretches so the queue
    // swings between empty and full.
    for (int n = 0; n < RandomCmds; n++) begin
      filling = ((n / 30) % 2) == 0;
      roll = $urandom_range(0, 99);
      v = ($urandom_range(0, 1) == 0) ? hot_values[$urandom_range(0, 7)] : $urandom;
      if (roll < 5) begin
        push_cmd(OP_NOP, $urandom);
      end else if (roll < 20) begin
        push_cmd(OP_LIST, $urandom);
      end else if (roll < (filling ? 80 : 45)) begin
        push_cmd(OP_ENQ, v);
      end else begin
        if ($urandom_range(0, 3) != 0) v = hot_values[$urandom_range(0, 7)];
        push_cmd(OP_DEL, v);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_resps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d commands and %0d results: %0d full, %0d not found,",
             cmds_taken, resps_seen, full_hits, miss_hits);
    $display("%0d listed entries, with a %0d-cycle output hold-off.", listed, HoldCycles);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
